>>> rtl/sact_pkg.sv
// shared types and constants of the cache tag controller
package sact_pkg;

    // cache geometry
    localparam int SETS        = 64;
    localparam int WAYS        = 4;
    localparam int BLOCK_BYTES = 16;

    // register indexes of the configuration port
    localparam logic [1:0] REG_WRITE_POLICY = 2'd0;
    localparam logic [1:0] REG_REPL_POLICY  = 2'd1;
    localparam logic [1:0] REG_RANDOM_SEED  = 2'd2;

    // write policy codes
    localparam logic WP_WRITE_BACK    = 1'b0;
    localparam logic WP_WRITE_THROUGH = 1'b1;

    // replacement policy codes, RP_FIRST_WAY always evicts way 0
    localparam logic [1:0] RP_LRU       = 2'd0;
    localparam logic [1:0] RP_FIFO      = 2'd1;
    localparam logic [1:0] RP_RANDOM    = 2'd2;
    localparam logic [1:0] RP_FIRST_WAY = 2'd3;

    // placement codes
    localparam logic [1:0] PL_HIT     = 2'd0;
    localparam logic [1:0] PL_INVALID = 2'd1;
    localparam logic [1:0] PL_EVICT   = 2'd2;
    localparam logic [1:0] PL_NONE    = 2'd3;

    localparam logic [15:0] LFSR_MASK = 16'hB400;

    // one accepted access, passed from the front part to the back part
    typedef struct packed {
        logic [31:0] address;
        logic        func;
    } t_req;

    // one result beat
    typedef struct packed {
        logic        hit;
        logic [3:0]  way;
        logic [11:0] set_index;
        logic        fill_needed;
        logic [27:0] fill_block;
        logic        writeback_needed;
        logic [27:0] writeback_block;
        logic        memory_write;
        logic        line_dirty;
        logic [1:0]  placement;
    } t_res;

    // galois lfsr step, right shift
    function automatic logic [15:0] lfsr_next(input logic [15:0] v);
        lfsr_next = v[0] ? ((v >> 1) ^ LFSR_MASK) : (v >> 1);
    endfunction

endpackage

>>> rtl/set_assoc_cache_tag_controller.sv
// top level of the set-associative cache tag and policy controller
//
// An access (address, func) is taken on a clock edge where i_start is high
// and o_busy is low; it enters a two-entry queue in front of the tag engine.
// The engine reads the set's ways one per cycle from the line memory, then
// writes the updated line and drives one result beat with o_done high for
// a single cycle. The receiver cannot stall; results are in input order.
// The engine takes no new access until the last one's line is written;
// the line memory is read one way at a time.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at
// once: index 0 write policy, 1 replacement policy, 2 random seed.
// After reset a sweep clears all SETS*WAYS lines of the line memory;
// accesses queue up meanwhile and are served once the sweep ends.
// Counters and stamps wrap at 32 bits.
module set_assoc_cache_tag_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_start,
    input  logic [31:0] i_address,
    input  logic        i_func,
    output logic        o_busy,
    output logic        o_done,
    output logic        o_hit,
    output logic [3:0]  o_way,
    output logic [11:0] o_set_index,
    output logic        o_fill_needed,
    output logic [27:0] o_fill_block,
    output logic        o_writeback_needed,
    output logic [27:0] o_writeback_block,
    output logic        o_memory_write,
    output logic        o_line_dirty,
    output logic [1:0]  o_placement
);
    import sact_pkg::*;

    t_req req;
    t_res res;
    logic req_valid, req_take;

    sact_front #(.DEPTH(2)) u_front (
        .i_clk, .i_rst_n, .i_start, .i_address, .i_func, .o_busy,
        .o_req(req), .o_req_valid(req_valid), .i_req_take(req_take)
    );

    sact_back u_back (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_req(req), .i_req_valid(req_valid), .o_req_take(req_take),
        .o_res(res), .o_res_valid(o_done)
    );

    assign o_hit              = res.hit;
    assign o_way              = res.way;
    assign o_set_index        = res.set_index;
    assign o_fill_needed      = res.fill_needed;
    assign o_fill_block       = res.fill_block;
    assign o_writeback_needed = res.writeback_needed;
    assign o_writeback_block  = res.writeback_block;
    assign o_memory_write     = res.memory_write;
    assign o_line_dirty       = res.line_dirty;
    assign o_placement        = res.placement;
endmodule

>>> rtl/sact_front.sv
// front part: accepts accesses and queues them for the back part
module sact_front #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [31:0]     i_address,
    input  logic            i_func,
    output logic            o_busy,
    output sact_pkg::t_req  o_req,
    output logic            o_req_valid,
    input  logic            i_req_take
);
    import sact_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_req            r_q [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;
    logic            push, pop;

    assign o_busy      = (r_cnt == (AW+1)'(DEPTH));
    assign push        = i_start && !o_busy;
    assign pop         = i_req_take && (r_cnt != '0);
    assign o_req_valid = (r_cnt != '0);
    assign o_req       = r_q[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{address: i_address, func: i_func};
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

>>> rtl/sact_back.sv
// back part: tag lookup, victim choice and line update, one way per cycle
module sact_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [15:0]     i_cfg_data,
    input  sact_pkg::t_req  i_req,
    input  logic            i_req_valid,
    output logic            o_req_take,
    output sact_pkg::t_res  o_res,
    output logic            o_res_valid
);
    import sact_pkg::*;

    localparam int OB    = $clog2(BLOCK_BYTES);
    localparam int SB    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int SETW  = $clog2(SETS);
    localparam int WB    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TW    = 32 - OB - SETW;
    localparam int LINES = SETS * WAYS;
    localparam int LB    = $clog2(LINES) + 1;

    typedef enum logic [2:0] {S_IDLE, S_CLEAR, S_READ, S_SCAN, S_WRITE} t_state;

    // line memory: valid, dirty, tag, last use, insert
    typedef struct packed {
        logic          valid;
        logic          dirty;
        logic [TW-1:0] tag;
        logic [31:0]   luse;
        logic [31:0]   ins;
    } t_line;

    t_line           r_mem [LINES];
    t_line           r_rd;
    t_state          r_state;
    logic [LB-1:0]   r_clr;
    logic            r_wp;
    logic [1:0]      r_rp;
    logic [15:0]     r_lfsr;
    logic [31:0]     r_acc;
    t_req            r_req;
    logic [WB:0]     r_w;
    logic            r_found, r_freed;
    logic [WB-1:0]   r_hway, r_fway, r_vway;
    logic [31:0]     r_hins;
    logic [31:0]     r_vstamp;
    logic [TW:0]     r_vt [WAYS];
    t_res            r_res;
    logic            r_res_valid;
    t_res            n_res;

    logic [27:0]     block;
    logic [SB-1:0]   set;
    logic [TW-1:0]   tag;
    logic [WB-1:0]   wcur;
    logic [LB-2:0]   raddr, waddr;
    logic            rd_re, mem_we;
    t_line           wline;
    logic [WB-1:0]   sel_way;
    logic            is_wr, wt, alloc;
    logic [31:0]     cstamp;
    logic [15:0]     lfsr_adv;

    // address split
    assign block = 28'(r_req.address >> OB);
    assign set   = (SETS > 1) ? SB'(r_req.address >> OB) : '0;
    assign tag   = TW'(r_req.address >> (OB + SETW));
    assign wcur  = WB'(r_w);
    assign is_wr = r_req.func;
    assign wt    = (r_wp == WP_WRITE_THROUGH);
    assign alloc = !(is_wr && wt);
    assign lfsr_adv = lfsr_next(r_lfsr);

    assign raddr = (LB-1)'(set * WAYS + wcur);
    assign rd_re = (r_state == S_READ) || (r_state == S_SCAN);
    assign cstamp = (r_rp == RP_FIFO) ? r_rd.ins : r_rd.luse;

    // chosen way at write time
    always_comb begin
        priority if (r_found)   sel_way = r_hway;
        else if (r_freed)       sel_way = r_fway;
        else if (r_rp == RP_RANDOM) sel_way = WB'(lfsr_adv % WAYS);
        else                    sel_way = r_vway;
    end

    // line write: clear sweep or update of the accessed way
    always_comb begin
        mem_we = 1'b0;
        waddr  = (LB-1)'(set * WAYS + sel_way);
        wline  = r_rd;
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
            waddr  = r_clr[LB-2:0];
            wline  = '0;
        end else if (r_state == S_WRITE && (r_found || alloc)) begin
            mem_we = 1'b1;
            if (r_found) begin
                wline.valid = 1'b1;
                wline.dirty = is_wr ? !wt : r_vt[r_hway][TW];
                wline.tag   = tag;
                wline.luse  = r_acc;
                wline.ins   = r_hins;
            end else begin
                wline.valid = 1'b1;
                wline.dirty = is_wr && !wt;
                wline.tag   = tag;
                wline.luse  = r_acc;
                wline.ins   = r_acc;
            end
        end
    end

    // line memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[waddr] <= wline;
        if (rd_re)  r_rd <= r_mem[raddr];
    end

    assign o_req_take  = (r_state == S_IDLE) && i_req_valid;
    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

    // sequencer: clear after reset, then read each way, then update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_wp        <= WP_WRITE_BACK;
            r_rp        <= RP_LRU;
            r_lfsr      <= 16'd1;
            r_acc       <= '0;
            r_res_valid <= 1'b0;
            r_w         <= '0;
        end else begin
            r_res_valid <= (r_state == S_WRITE);
            // register writes; else a random eviction steps the lfsr
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_WRITE_POLICY: r_wp <= i_cfg_data[0];
                    REG_REPL_POLICY:  r_rp <= i_cfg_data[1:0];
                    REG_RANDOM_SEED:  r_lfsr <= (i_cfg_data == '0) ? 16'd1 : i_cfg_data;
                    default: ;
                endcase
            end else if (r_state == S_WRITE && !r_found && !r_freed && alloc
                         && r_rp == RP_RANDOM) begin
                r_lfsr <= lfsr_adv;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == LB'(LINES-1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_req   <= i_req;
                        r_w     <= '0;
                        r_found <= 1'b0;
                        r_freed <= 1'b0;
                        r_acc   <= r_acc + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_w     <= r_w + 1'b1;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    // examine the way read last cycle
                    if (!r_found && r_rd.valid && r_rd.tag == tag) begin
                        r_found <= 1'b1;
                        r_hway  <= WB'(r_w - 1'b1);
                        r_hins  <= r_rd.ins;
                    end
                    if (!r_freed && !r_rd.valid) begin
                        r_freed <= 1'b1;
                        r_fway  <= WB'(r_w - 1'b1);
                    end
                    if (r_w == (WB+1)'(1) || cstamp < r_vstamp
                        || r_rp == RP_RANDOM || r_rp == RP_FIRST_WAY) begin
                        if (r_w == (WB+1)'(1) || r_rp == RP_LRU || r_rp == RP_FIFO) begin
                            r_vway   <= WB'(r_w - 1'b1);
                            r_vstamp <= cstamp;
                        end
                    end
                    if (r_w == (WB+1)'(WAYS)) r_state <= S_WRITE;
                    else r_w <= r_w + 1'b1;
                end
                S_WRITE: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // dirty bit and tag of every way, kept while scanning
    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN) r_vt[WB'(r_w - 1'b1)] <= {r_rd.dirty, r_rd.tag};
    end

    // result beat contents
    always_comb begin
        n_res              = '0;
        n_res.hit          = r_found;
        n_res.set_index    = 12'(set);
        n_res.memory_write = is_wr && wt;
        if (r_found) begin
            n_res.way        = 4'(r_hway);
            n_res.placement  = PL_HIT;
            n_res.line_dirty = is_wr ? !wt : r_vt[r_hway][TW];
        end else if (!alloc) begin
            n_res.placement  = PL_NONE;
        end else begin
            n_res.way         = 4'(sel_way);
            n_res.placement   = r_freed ? PL_INVALID : PL_EVICT;
            n_res.line_dirty  = is_wr && !wt;
            n_res.fill_needed = 1'b1;
            n_res.fill_block  = block;
            if (!r_freed && !wt && r_vt[sel_way][TW]) begin
                n_res.writeback_needed = 1'b1;
                n_res.writeback_block  =
                    28'((32'(r_vt[sel_way][TW-1:0]) << SETW) | 32'(set));
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) r_res <= n_res;
    end
endmodule

>>> rtl/sact_checker.sv
// port-level assertions for the cache tag controller, bound to the top level
module sact_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_done,
    input logic        o_hit,
    input logic        o_fill_needed,
    input logic        o_writeback_needed,
    input logic        o_memory_write,
    input logic [1:0]  o_placement
);
    import sact_pkg::*;

    // a hit never fills
    a_hit_no_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_hit |-> !o_fill_needed && o_placement == PL_HIT)
        else $error("hit with fill");

    // write-back only on policy eviction
    a_wb_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_writeback_needed |-> o_placement == PL_EVICT)
        else $error("write-back without eviction");

    // no write-back for a write-through store
    a_wt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_memory_write |-> !o_writeback_needed)
        else $error("write-back with memory write");

    // results are single-cycle beats
    a_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("back-to-back results");
endmodule

bind set_assoc_cache_tag_controller sact_checker u_sact_checker (
    .i_clk, .i_rst_n, .o_done, .o_hit, .o_fill_needed,
    .o_writeback_needed, .o_memory_write, .o_placement
);

>>> verif/tb_set_assoc_cache_tag_controller.sv
// self-checking testbench of the set-associative cache tag controller
module tb_set_assoc_cache_tag_controller;
    timeunit 1ns;
    timeprecision 1ps;

    import sact_pkg::*;

    localparam int NSETS   = SETS;
    localparam int NWAYS   = WAYS;
    localparam int OFFS    = $clog2(BLOCK_BYTES);
    localparam int NLINES  = NSETS * NWAYS;
    localparam int IDLE_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_start = 1'b0;
    logic [31:0] i_address = '0;
    logic        i_func = 1'b0;
    logic        o_busy, o_done, o_hit, o_fill_needed, o_writeback_needed;
    logic        o_memory_write, o_line_dirty;
    logic [3:0]  o_way;
    logic [11:0] o_set_index;
    logic [27:0] o_fill_block, o_writeback_block;
    logic [1:0]  o_placement;

    set_assoc_cache_tag_controller uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_start(i_start), .i_address(i_address),
        .i_func(i_func), .o_busy(o_busy), .o_done(o_done), .o_hit(o_hit),
        .o_way(o_way), .o_set_index(o_set_index), .o_fill_needed(o_fill_needed),
        .o_fill_block(o_fill_block), .o_writeback_needed(o_writeback_needed),
        .o_writeback_block(o_writeback_block), .o_memory_write(o_memory_write),
        .o_line_dirty(o_line_dirty), .o_placement(o_placement)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // mirror of the tag store and policy state
    logic        cfg_wp;
    logic [1:0]  cfg_rp;
    logic [15:0] lfsr_q;
    logic        m_valid [NLINES];
    logic        m_dirty [NLINES];
    logic [27:0] m_tag   [NLINES];
    logic [31:0] m_used  [NLINES];
    logic [31:0] m_born  [NLINES];
    logic [31:0] acc_cnt;

    t_res lookups_due[$];
    int   errors = 0;
    int   idle_cycles = 0;

    // predict the result beat of one access and update the mirror
    function automatic t_res lookup_predict(input logic [31:0] addr, input logic wr);
        t_res r;
        logic [27:0] blk;
        logic [11:0] set;
        logic [27:0] tag;
        int base, w, v;
        logic found, freed;
        r = '0;
        blk = 28'(addr >> OFFS);
        set = 12'(blk % NSETS);
        tag = 28'(blk / NSETS);
        base = int'(set) * NWAYS;
        found = 1'b0;
        freed = 1'b0;
        v = 0;
        acc_cnt = acc_cnt + 1;
        r.set_index = set;
        r.memory_write = wr && cfg_wp == WP_WRITE_THROUGH;
        for (w = 0; w < NWAYS; w++)
            if (!found && m_valid[base+w] && m_tag[base+w] == tag) begin
                found = 1'b1;
                v = w;
            end
        if (found) begin
            r.hit = 1'b1;
            r.placement = PL_HIT;
            m_used[base+v] = acc_cnt;
            if (wr) m_dirty[base+v] = (cfg_wp == WP_WRITE_BACK);
            r.line_dirty = m_dirty[base+v];
            r.way = 4'(v);
        end else if (wr && cfg_wp == WP_WRITE_THROUGH) begin
            r.placement = PL_NONE;
        end else begin
            for (w = 0; w < NWAYS; w++)
                if (!freed && !m_valid[base+w]) begin
                    freed = 1'b1;
                    v = w;
                end
            if (freed) begin
                r.placement = PL_INVALID;
            end else begin
                r.placement = PL_EVICT;
                v = 0;
                if (cfg_rp == RP_LRU) begin
                    for (w = 1; w < NWAYS; w++)
                        if (m_used[base+w] < m_used[base+v]) v = w;
                end else if (cfg_rp == RP_FIFO) begin
                    for (w = 1; w < NWAYS; w++)
                        if (m_born[base+w] < m_born[base+v]) v = w;
                end else if (cfg_rp == RP_RANDOM) begin
                    lfsr_q = lfsr_q[0] ? ((lfsr_q >> 1) ^ 16'hB400) : (lfsr_q >> 1);
                    v = int'(lfsr_q % NWAYS);
                end
                if (m_dirty[base+v] && cfg_wp == WP_WRITE_BACK) begin
                    r.writeback_needed = 1'b1;
                    r.writeback_block = 28'(m_tag[base+v] * NSETS + set);
                end
            end
            m_valid[base+v] = 1'b1;
            m_tag[base+v] = tag;
            m_dirty[base+v] = wr && cfg_wp == WP_WRITE_BACK;
            m_used[base+v] = acc_cnt;
            m_born[base+v] = acc_cnt;
            r.fill_needed = 1'b1;
            r.fill_block = blk;
            r.line_dirty = m_dirty[base+v];
            r.way = 4'(v);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    // result checker and stall watchdog
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_done) begin
            if (lookups_due.size() == 0) begin
                report_mismatch("unexpected beat", 32'(o_set_index), 32'd0);
            end else begin
                e = lookups_due.pop_front();
                if (o_hit != e.hit) report_mismatch("hit", 32'(o_hit), 32'(e.hit));
                if (o_way != e.way) report_mismatch("way", 32'(o_way), 32'(e.way));
                if (o_set_index != e.set_index)
                    report_mismatch("set_index", 32'(o_set_index), 32'(e.set_index));
                if (o_fill_needed != e.fill_needed)
                    report_mismatch("fill_needed", 32'(o_fill_needed),
                                    32'(e.fill_needed));
                if (o_fill_block != e.fill_block)
                    report_mismatch("fill_block", 32'(o_fill_block), 32'(e.fill_block));
                if (o_writeback_needed != e.writeback_needed)
                    report_mismatch("writeback_needed", 32'(o_writeback_needed),
                                    32'(e.writeback_needed));
                if (o_writeback_block != e.writeback_block)
                    report_mismatch("writeback_block", 32'(o_writeback_block),
                                    32'(e.writeback_block));
                if (o_memory_write != e.memory_write)
                    report_mismatch("memory_write", 32'(o_memory_write),
                                    32'(e.memory_write));
                if (o_line_dirty != e.line_dirty)
                    report_mismatch("line_dirty", 32'(o_line_dirty), 32'(e.line_dirty));
                if (o_placement != e.placement)
                    report_mismatch("placement", 32'(o_placement), 32'(e.placement));
            end
        end
        if (o_done || (i_start && !o_busy)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // send one access beat after a random gap; start stays high on a zero gap
    task automatic send_access(input logic [31:0] addr, input logic wr);
        int gap;
        gap = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_address <= addr;
        i_func <= wr;
        do @(posedge i_clk); while (o_busy);
        lookups_due.push_back(lookup_predict(addr, wr));
    endtask

    // wait until every accepted beat has come back
    task automatic drain();
        i_start <= 1'b0;
        while (lookups_due.size() != 0) @(posedge i_clk);
    endtask

    // register write while idle
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        drain();
        repeat (12) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_WRITE_POLICY) cfg_wp = val[0];
        else if (idx == REG_REPL_POLICY) cfg_rp = val[1:0];
        else if (idx == REG_RANDOM_SEED) lfsr_q = (val == 0) ? 16'd1 : val;
    endtask

    // address in one of a few hot sets with a few tags, to force conflicts
    function automatic logic [31:0] hot_addr();
        logic [31:0] a;
        a = $urandom;
        a[9:4] = 6'($urandom_range(0, 3));
        a[31:10] = 22'($urandom_range(0, 7)) | ($urandom_range(0, 15) == 0 ? 22'h3FFFF8 : 22'h0);
        return a;
    endfunction

    task automatic test_directed();
        send_access(32'h0000_0000, 1'b0);
        send_access(32'hFFFF_FFFF, 1'b1);
        send_access(32'h0000_000F, 1'b0);
        send_access(32'hFFFF_FFF0, 1'b0);
        for (int t = 1; t <= 5; t++) send_access(32'(t) << 10, 1'b1);
        send_access(32'h0000_0400, 1'b0);
        write_reg(REG_WRITE_POLICY, 16'(WP_WRITE_THROUGH));
        send_access(32'h0000_0400, 1'b1);
        send_access(32'h0000_7000, 1'b1);
        send_access(32'h0000_1400, 1'b0);
        send_access(32'h0000_0800, 1'b0);
        write_reg(REG_WRITE_POLICY, 16'(WP_WRITE_BACK));
        write_reg(REG_REPL_POLICY, 16'(RP_FIFO));
        for (int t = 6; t <= 8; t++) send_access(32'(t) << 10, 1'b0);
        write_reg(REG_REPL_POLICY, 16'(RP_FIRST_WAY));
        send_access(32'h0000_2400, 1'b1);
        send_access(32'h0000_2800, 1'b0);
        write_reg(REG_RANDOM_SEED, 16'd0);
        write_reg(REG_REPL_POLICY, 16'(RP_RANDOM));
        for (int t = 9; t <= 12; t++) send_access(32'(t) << 10, 1'b1);
    endtask

    task automatic test_random_phase(input logic wp, input logic [1:0] rp,
                                     input logic [15:0] seed, input int n);
        write_reg(REG_WRITE_POLICY, 16'(wp));
        write_reg(REG_REPL_POLICY, 16'(rp));
        write_reg(REG_RANDOM_SEED, seed);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) < 8) send_access(hot_addr(), 1'($urandom));
            else send_access($urandom, 1'($urandom));
        end
    endtask

    initial begin
        cfg_wp = WP_WRITE_BACK;
        cfg_rp = RP_LRU;
        lfsr_q = 16'd1;
        acc_cnt = '0;
        for (int i = 0; i < NLINES; i++) begin
            m_valid[i] = 1'b0;
            m_dirty[i] = 1'b0;
            m_tag[i] = '0;
            m_used[i] = '0;
            m_born[i] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_phase(WP_WRITE_BACK, RP_LRU, 16'd1, 300);
        test_random_phase(WP_WRITE_BACK, RP_FIFO, 16'hFFFF, 300);
        test_random_phase(WP_WRITE_BACK, RP_RANDOM, 16'hACE1, 300);
        test_random_phase(WP_WRITE_THROUGH, RP_LRU, 16'h8000, 250);
        test_random_phase(WP_WRITE_THROUGH, RP_RANDOM, 16'($urandom_range(1, 65535)), 250);
        test_random_phase(WP_WRITE_BACK, RP_FIRST_WAY, 16'h0001, 100);
        test_random_phase(WP_WRITE_BACK, RP_LRU, 16'h0002, 100);
        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
